// ===== sv/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the adaptive position smoother.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int HistDepth = 5;
  localparam int StillMin  = 4;
  localparam int HistCntW  = $clog2(HistDepth + 1);
  localparam int HistIdxW  = $clog2(HistDepth);

  localparam logic [15:0] DtMax    = 16'd3277;
  localparam logic [32:0] AbsMin   = 33'd26;
  localparam logic [32:0] AbsMax   = 33'd12800;
  localparam logic [32:0] JumpAxis = 33'd512000;
  localparam logic [63:0] JumpSq   = 64'd262144000000;
  localparam logic [32:0] SuppAxis = 33'd2560;
  localparam logic [63:0] SuppSq   = 64'd6553600;
  localparam logic [15:0] OneQ8    = 16'd256;
  localparam int          QueueDepth = 2;

  // configuration register indexes
  localparam logic [2:0] RegHorizAmount = 3'd0;
  localparam logic [2:0] RegHorizDamp   = 3'd1;
  localparam logic [2:0] RegHorizStop   = 3'd2;
  localparam logic [2:0] RegVertAmount  = 3'd3;
  localparam logic [2:0] RegVertDamp    = 3'd4;
  localparam logic [2:0] RegVertStop    = 3'd5;
  localparam logic [2:0] RegBypass      = 3'd6;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        dt;
    logic               air;
    logic               indoor;
    logic               still;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

// ===== sv/aps_front.sv =====
// ----------------------------------------------------------------------------
// aps_front
// Accepts raw samples, keeps the x,y history and flags standstill.
// ----------------------------------------------------------------------------
module aps_front import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [15:0]        frame_time,
  input  logic               in_air,
  input  logic               interior,
  output logic               q_push,
  input  logic               q_full,
  output item_t              q_item
);

  logic [63:0]         hist [HistDepth];
  logic [HistCntW-1:0] hist_count;
  logic                still;
  logic                take;
  logic [63:0]         cur;

  assign full = q_full;
  assign take = push && !q_full;
  assign cur  = {pos_x, pos_y};

  // standstill: at least StillMin entries written, all equal to the oldest one
  always_comb begin
    still = (hist_count >= HistCntW'(StillMin));
    for (int i = 1; i < HistDepth; i++) begin
      if (HistCntW'(i) < hist_count && hist[i] != hist[0]) still = 1'b0;
    end
  end

  // history shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count <= '0;
    end else if (take) begin
      if (hist_count < HistCntW'(HistDepth)) begin
        hist[hist_count[HistIdxW-1:0]] <= cur;
        hist_count <= hist_count + 1'b1;
      end else begin
        for (int i = 1; i < HistDepth; i++) hist[i-1] <= hist[i];
        hist[HistDepth-1] <= cur;
      end
    end
  end

  assign q_push        = take;
  assign q_item.px     = pos_x;
  assign q_item.py     = pos_y;
  assign q_item.pz     = pos_z;
  assign q_item.dt     = (frame_time > DtMax) ? DtMax : frame_time;
  assign q_item.air    = in_air;
  assign q_item.indoor = interior;
  assign q_item.still  = still;

endmodule

// ===== sv/aps_queue.sv =====
// ----------------------------------------------------------------------------
// aps_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module aps_queue import aps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  output logic  q_full,
  input  item_t wdata,
  input  logic  rd,
  output logic  q_empty,
  output item_t rdata
);

  localparam int PtrW = $clog2(QueueDepth);

  item_t           mem [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [PtrW:0]   count;

  assign q_full  = (count == (PtrW+1)'(QueueDepth));
  assign q_empty = (count == '0);
  assign rdata   = mem[rptr];

  // storage write
  always_ff @(posedge clk) begin
    if (wr && !q_full) mem[wptr] <= wdata;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !q_full) wptr <= wptr + 1'b1;
      if (rd && !q_empty) rptr <= rptr + 1'b1;
      count <= count + (PtrW+1)'(wr && !q_full) - (PtrW+1)'(rd && !q_empty);
    end
  end

endmodule

// ===== sv/aps_div.sv =====
// ----------------------------------------------------------------------------
// aps_div
// Restoring divider, one quotient bit per cycle, 64 by 48 bits.
// ----------------------------------------------------------------------------
module aps_div import aps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] q;
  logic [48:0] rem;
  logic [47:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [48:0] sh;

  assign sh   = {rem[47:0], q[63]};
  assign quo  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (sh >= {1'b0, d}) begin
          rem <= sh - {1'b0, d};
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/aps_back.sv =====
// ----------------------------------------------------------------------------
// aps_back
// Carries out snap, smoothing steps and suppression; one axis at a time.
// ----------------------------------------------------------------------------
module aps_back import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  item_t              item,
  output logic               q_pop,
  input  logic [15:0]        horiz_amount_r,
  input  logic [15:0]        horiz_damping_r,
  input  logic [15:0]        horiz_stop_r,
  input  logic [15:0]        vert_amount_r,
  input  logic [15:0]        vert_damping_r,
  input  logic [15:0]        vert_stop_r,
  input  logic [1:0]         bypass_r,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] offset_x,
  output logic signed [31:0] offset_y,
  output logic signed [31:0] offset_z,
  output logic               standing_still,
  output logic               suppressed
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_JUMP  = 11'b00000000010,
    S_JSQ   = 11'b00000000100,
    S_DEN1  = 11'b00000001000,
    S_DEN2  = 11'b00000010000,
    S_AXIS  = 11'b00000100000,
    S_MUL1  = 11'b00001000000,
    S_MUL2  = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_SUPP  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic signed [31:0] smooth [3];
  logic signed [31:0] applied_x;
  logic signed [31:0] applied_y;
  logic               awaiting_start;
  item_t              cur;
  logic [1:0]         axis;
  logic [31:0]        den_part;
  logic [47:0]        den_h;
  logic [47:0]        den_v;
  logic signed [32:0] dd [3];
  logic [63:0]        acc;
  logic [47:0]        mprod;
  logic               out_valid;
  logic               jump_axis;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_q;
  logic [47:0]        den_sel;
  logic [32:0]        m_cur;
  logic [32:0]        a_cur;
  logic signed [31:0] p_cur;
  logic               byp_cur;
  logic signed [31:0] ox;
  logic signed [31:0] oy;
  logic signed [31:0] oz;
  logic signed [32:0] ex;
  logic signed [32:0] ey;
  logic               q_take;
  logic [32:0]        mag_d [3];
  logic [39:0]        sq_d [3];
  logic [32:0]        mag_ex;
  logic [32:0]        mag_ey;
  logic [23:0]        sq_ex;
  logic [23:0]        sq_ey;
  logic [32:0]        q_clip;

  assign q_take = (state == S_IDLE) && !q_empty && !out_valid;
  assign q_pop  = q_take;
  assign empty  = !out_valid;

  // per-axis selections
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = mag33(dd[i]);
      sq_d[i]  = 40'(mag_d[i][19:0]) * 40'(mag_d[i][19:0]);
    end
    case (axis)
      2'd0:    p_cur = cur.px;
      2'd1:    p_cur = cur.py;
      default: p_cur = cur.pz;
    endcase
    m_cur   = mag_d[axis];
    a_cur   = (m_cur < AbsMin) ? AbsMin : ((m_cur > AbsMax) ? AbsMax : m_cur);
    den_sel = (axis == 2'd2) ? den_v : den_h;
    byp_cur = cur.indoor && ((axis == 2'd2) ? bypass_r[1] : bypass_r[0]);
    jump_axis = (mag_d[0] > JumpAxis) || (mag_d[1] > JumpAxis) ||
                (mag_d[2] > JumpAxis);
    mag_ex  = mag33(ex);
    mag_ey  = mag33(ey);
    sq_ex   = 24'(mag_ex[11:0]) * 24'(mag_ex[11:0]);
    sq_ey   = 24'(mag_ey[11:0]) * 24'(mag_ey[11:0]);
    // any quotient of 2^32 or more saturates the step
    q_clip  = (div_q[63:32] != '0) ? 33'h100000000 : {1'b0, div_q[31:0]};
  end

  aps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (den_sel),
    .done  (div_done),
    .quo   (div_q)
  );

  assign div_start = (state == S_MUL2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      awaiting_start <= 1'b1;
      smooth[0]      <= '0;
      smooth[1]      <= '0;
      smooth[2]      <= '0;
      applied_x      <= '0;
      applied_y      <= '0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur <= item;
            if (awaiting_start && item.pz != 0) begin
              smooth[0] <= item.px;
              smooth[1] <= item.py;
              smooth[2] <= item.pz;
              awaiting_start <= 1'b0;
            end
            state <= S_JUMP;
          end
        end
        // differences against smoothed state
        S_JUMP: begin
          dd[0] <= 33'(cur.px) - 33'(smooth[0]);
          dd[1] <= 33'(cur.py) - 33'(smooth[1]);
          dd[2] <= 33'(cur.pz) - 33'(smooth[2]);
          state <= S_JSQ;
        end
        // jump test; squares of values below 2^19 in magnitude
        S_JSQ: begin
          if (cur.air || jump_axis ||
              (64'(sq_d[0]) + 64'(sq_d[1]) + 64'(sq_d[2]) > JumpSq)) begin
            smooth[0] <= cur.px;
            smooth[1] <= cur.py;
            smooth[2] <= cur.pz;
            state <= S_SUPP;
          end else begin
            den_part <= horiz_amount_r * horiz_damping_r;
            state    <= S_DEN1;
          end
        end
        S_DEN1: begin
          den_h    <= den_part * (cur.still ? horiz_stop_r : OneQ8);
          den_part <= vert_amount_r * vert_damping_r;
          state    <= S_DEN2;
        end
        S_DEN2: begin
          den_v <= den_part * (cur.still ? vert_stop_r : OneQ8);
          axis  <= 2'd0;
          state <= S_AXIS;
        end
        S_AXIS: begin
          if (byp_cur || den_sel == '0) begin
            smooth[axis] <= p_cur;
            if (axis == 2'd2) state <= S_SUPP;
            else axis <= axis + 1'b1;
          end else begin
            // m * a: m up to 33 bits, a up to 14 bits
            mprod <= 48'(m_cur) * 48'(a_cur[13:0]);
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc   <= 64'(mprod) * 64'(cur.dt);
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            smooth[axis] <= sat32(dd[axis][32]
              ? 34'(smooth[axis]) - 34'(q_clip)
              : 34'(smooth[axis]) + 34'(q_clip));
            if (axis == 2'd2) state <= S_SUPP;
            else begin
              axis  <= axis + 1'b1;
              state <= S_AXIS;
            end
          end
        end
        // standstill suppression
        S_SUPP: begin
          ex    <= 33'(ox) - 33'(applied_x);
          ey    <= 33'(oy) - 33'(applied_y);
          offset_x <= ox;
          offset_y <= oy;
          offset_z <= oz;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            standing_still <= cur.still;
            if (cur.still && ((mag_ex > SuppAxis) || (mag_ey > SuppAxis) ||
                (64'(sq_ex) + 64'(sq_ey) > SuppSq))) begin
              suppressed <= 1'b1;
              smooth[0]  <= cur.px;
              smooth[1]  <= cur.py;
              offset_x   <= '0;
              offset_y   <= '0;
              offset_z   <= '0;
            end else begin
              suppressed <= 1'b0;
              applied_x  <= offset_x;
              applied_y  <= offset_y;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ox = sat32(34'(smooth[0]) - 34'(cur.px));
  assign oy = sat32(34'(smooth[1]) - 34'(cur.py));
  assign oz = sat32(34'(smooth[2]) - 34'(cur.pz));

endmodule

// ===== sv/adaptive_position_smoother.sv =====
// ----------------------------------------------------------------------------
// adaptive_position_smoother
// Smooths a raw 3D position per frame and reports smoothed-minus-raw offsets.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: push/full; a beat is taken when push is high, full low
//   result channel: empty/pop; the head result sits on the ports while empty
//     is low and leaves on a cycle with pop high
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//     ready; unknown indexes are dropped
// Paths: a snapped item skips the smoothing steps; an axis that steps waits
//   on the bit-serial divider, which is shared across the axes; a bypassed
//   axis skips the divider
// Flow: the back starts the next queued item the cycle after a pop; the
//   front and a two-entry queue keep accepting while the back works
// Reset: synchronous rst clears smoothed state, applied x,y offsets and
//   history count, sets gains to 1.0, waits for the first item with nonzero z
// A stalled receiver holds the result; the back then waits before the next
//   item and the queue fills, raising full
// ----------------------------------------------------------------------------
module adaptive_position_smoother import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [15:0]        frame_time,
  input  logic               in_air,
  input  logic               interior,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] offset_x,
  output logic signed [31:0] offset_y,
  output logic signed [31:0] offset_z,
  output logic               standing_still,
  output logic               suppressed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] horiz_amount;
  logic [15:0] horiz_damping;
  logic [15:0] horiz_stop_mult;
  logic [15:0] vert_amount;
  logic [15:0] vert_damping;
  logic [15:0] vert_stop_mult;
  logic [1:0]  interior_bypass;
  logic        q_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  item_t       q_in;
  item_t       q_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_amount    <= OneQ8;
      horiz_damping   <= OneQ8;
      horiz_stop_mult <= OneQ8;
      vert_amount     <= OneQ8;
      vert_damping    <= OneQ8;
      vert_stop_mult  <= OneQ8;
      interior_bypass <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegHorizAmount: horiz_amount    <= cfg_data;
        RegHorizDamp:   horiz_damping   <= cfg_data;
        RegHorizStop:   horiz_stop_mult <= cfg_data;
        RegVertAmount:  vert_amount     <= cfg_data;
        RegVertDamp:    vert_damping    <= cfg_data;
        RegVertStop:    vert_stop_mult  <= cfg_data;
        RegBypass:      interior_bypass <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  aps_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .frame_time(frame_time),
    .in_air(in_air), .interior(interior),
    .q_push(q_push), .q_full(q_full), .q_item(q_in)
  );

  aps_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .q_full(q_full), .wdata(q_in),
    .rd(q_pop), .q_empty(q_empty), .rdata(q_out)
  );

  aps_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .item(q_out), .q_pop(q_pop),
    .horiz_amount_r(horiz_amount), .horiz_damping_r(horiz_damping),
    .horiz_stop_r(horiz_stop_mult), .vert_amount_r(vert_amount),
    .vert_damping_r(vert_damping), .vert_stop_r(vert_stop_mult),
    .bypass_r(interior_bypass), .empty(empty), .pop(pop),
    .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
    .standing_still(standing_still), .suppressed(suppressed)
  );

  // a suppressed result carries zero offsets
  a_supp_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && suppressed) |-> (offset_x == 0 && offset_y == 0 && offset_z == 0))
    else $error("suppressed result with nonzero offset");

  // suppression only while standing still
  a_supp_still: assert property (@(posedge clk) disable iff (rst)
    (!empty && suppressed) |-> standing_still)
    else $error("suppression without standstill");

  // a held result keeps offset_x and suppressed stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(offset_x) && $stable(suppressed)))
    else $error("result changed while held");

endmodule

// ===== tb/adaptive_position_smoother_tb.sv =====
// ----------------------------------------------------------------------------
// adaptive_position_smoother_tb
// Drives raw positions through the smoother under random push/pop gaps and
// compares every offset beat against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module adaptive_position_smoother_tb import aps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic               still;
    logic               supp;
  } offset_beat_t;

  // smoother state mirror and expected offsets
  class offset_scoreboard;
    logic [15:0] gain [0:5];
    logic [1:0]  bypass;
    logic signed [31:0] sx, sy, sz, ax, ay;
    logic [63:0] hist [0:4];
    int          hcnt;
    bit          wait_start;
    offset_beat_t pending [$];
    int          errors;

    function new();
      for (int i = 0; i < 6; i++) gain[i] = 16'd256;
      bypass = 0; sx = 0; sy = 0; sz = 0; ax = 0; ay = 0;
      hcnt = 0; wait_start = 1; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx == RegBypass) bypass = val[1:0];
      else if (idx <= RegVertStop) gain[idx] = val;
    endfunction

    static function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function logic signed [31:0] step_axis(logic signed [31:0] s,
        logic signed [31:0] p, logic [63:0] den, logic [15:0] dt);
      longint d;
      logic [63:0] m, a, q;
      d = longint'(p) - longint'(s);
      m = d < 0 ? -d : d;
      a = m < 26 ? 26 : (m > 12800 ? 12800 : m);
      if (den == 0) return p;
      q = m * a * dt / den;
      return clip32(d < 0 ? longint'(s) - longint'(q) : longint'(s) + longint'(q));
    endfunction

    function void note_item(logic signed [31:0] px, py, pz, logic [15:0] dt_in,
                            bit air, bit indoor);
      offset_beat_t r;
      logic [15:0] dt;
      bit still, supp, jmp;
      logic [63:0] cur, hs, vs, mx, my, mz;
      longint dx, dy, dz, ox, oy, oz, ex, ey;
      dt = dt_in > 16'd3277 ? 16'd3277 : dt_in;
      cur = {px, py};
      if (wait_start && pz != 0) begin
        sx = px; sy = py; sz = pz; wait_start = 0;
      end
      still = 0;
      if (hcnt >= 4) begin
        still = 1;
        for (int i = 1; i < hcnt; i++) if (hist[i] != hist[0]) still = 0;
      end
      if (hcnt < 5) begin
        hist[hcnt] = cur; hcnt++;
      end else begin
        for (int i = 1; i < 5; i++) hist[i-1] = hist[i];
        hist[4] = cur;
      end
      dx = longint'(px) - sx; dy = longint'(py) - sy; dz = longint'(pz) - sz;
      mx = dx < 0 ? -dx : dx; my = dy < 0 ? -dy : dy; mz = dz < 0 ? -dz : dz;
      if (mx > 512000 || my > 512000 || mz > 512000) jmp = 1;
      else jmp = 64'(dx*dx) + 64'(dy*dy) + 64'(dz*dz) > 64'd262144000000;
      if (air || jmp) begin
        sx = px; sy = py; sz = pz;
      end else begin
        hs = still ? gain[RegHorizStop] : 256;
        vs = still ? gain[RegVertStop] : 256;
        if (bypass[0] && indoor) begin
          sx = px; sy = py;
        end else begin
          sx = step_axis(sx, px, 64'(gain[RegHorizAmount]) * gain[RegHorizDamp] * hs, dt);
          sy = step_axis(sy, py, 64'(gain[RegHorizAmount]) * gain[RegHorizDamp] * hs, dt);
        end
        if (bypass[1] && indoor) sz = pz;
        else sz = step_axis(sz, pz, 64'(gain[RegVertAmount]) * gain[RegVertDamp] * vs, dt);
      end
      ox = clip32(longint'(sx) - px);
      oy = clip32(longint'(sy) - py);
      oz = clip32(longint'(sz) - pz);
      supp = 0;
      if (still) begin
        ex = ox - ax; ey = oy - ay;
        if ((ex < 0 ? -ex : ex) > 2560 || (ey < 0 ? -ey : ey) > 2560) supp = 1;
        else supp = 64'(ex*ex) + 64'(ey*ey) > 64'd6553600;
      end
      if (supp) begin
        sx = px; sy = py; ox = 0; oy = 0; oz = 0;
      end else begin
        ax = ox; ay = oy;
      end
      r.ox = ox; r.oy = oy; r.oz = oz; r.still = still; r.supp = supp;
      pending.push_back(r);
    endfunction

    function void check_beat(offset_beat_t got);
      offset_beat_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected offset beat %h", $time, got);
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.ox !== exp.ox) begin
        $display("%0t offset_x exp %0d got %0d", $time, exp.ox, got.ox); errors++;
      end
      if (got.oy !== exp.oy) begin
        $display("%0t offset_y exp %0d got %0d", $time, exp.oy, got.oy); errors++;
      end
      if (got.oz !== exp.oz) begin
        $display("%0t offset_z exp %0d got %0d", $time, exp.oz, got.oz); errors++;
      end
      if (got.still !== exp.still) begin
        $display("%0t standing_still exp %0b got %0b", $time, exp.still, got.still);
        errors++;
      end
      if (got.supp !== exp.supp) begin
        $display("%0t suppressed exp %0b got %0b", $time, exp.supp, got.supp);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, cfg_valid = 0;
  logic full, empty, cfg_ready, standing_still, suppressed;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [31:0] offset_x, offset_y, offset_z;
  logic [15:0] frame_time = 0, cfg_data = 0;
  logic [2:0]  cfg_index = 0;
  logic in_air = 0, interior = 0;

  offset_scoreboard board = new();
  bit  quiet_tail = 0;
  int  hold_off = 0;
  longint cycle_count = 0;
  logic signed [31:0] base_x, base_y, base_z;

  adaptive_position_smoother dut (.*);

  initial forever #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random pop gaps, optional long hold-off
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_beat({offset_x, offset_y, offset_z, standing_still, suppressed});
  end
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        pop <= 0; hold_off--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        pop <= 1;
      end else pop <= 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // push stays high after the beat so that items can follow back to back
  task automatic send_pos(logic signed [31:0] x, y, z, logic [15:0] dt,
                          bit air, bit indoor);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    push <= 1; pos_x <= x; pos_y <= y; pos_z <= z;
    frame_time <= dt; in_air <= air; interior <= indoor;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_item(x, y, z, dt, air, indoor);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd3277;
      default: return 16'($urandom_range(0, 3300));
    endcase
  endfunction

  // a short walk around a base point, with standstill runs
  task automatic random_walk(int n);
    logic signed [31:0] x, y, z;
    x = base_x; y = base_y; z = base_z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin x = $urandom; y = $urandom; z = $urandom; end
        1, 2: ;
        3: begin x = x + $signed($urandom_range(0, 8000)) - 4000; end
        default: begin
          x = x + $signed($urandom_range(0, 1200)) - 600;
          y = y + $signed($urandom_range(0, 1200)) - 600;
          z = z + $signed($urandom_range(0, 600)) - 300;
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(3, 6)) send_pos(x, y, z, rand_dt(),
                                               $urandom_range(0, 30) == 0, $urandom_range(0, 1));
      else send_pos(x, y, z, rand_dt(), $urandom_range(0, 30) == 0, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: start waiting on z, extremes, standstill and suppression
    send_pos(32'sd1000, 32'sd2000, 32'sd0, 16'd3277, 0, 0);
    send_pos(32'sd1000, 32'sd2000, 32'sd500, 16'd3277, 0, 0);
    send_pos(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'hffff, 0, 1);
    send_pos(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'd0, 1, 0);
    send_pos(32'sd0, 32'sd0, 32'sd0, 16'd100, 0, 0);
    send_pos(32'sd20, 32'sd0, 32'sd3, 16'd3277, 0, 0);
    send_pos(32'sd400000, 32'sd400000, 32'sd0, 16'd3277, 0, 0);
    repeat (6) send_pos(32'sd400100, 32'sd400000, 32'sd10, 16'd3277, 0, 0);
    send_pos(32'sd410000, 32'sd400000, 32'sd10, 16'd3277, 0, 0);
    repeat (5) send_pos(32'sd410000, 32'sd400000, 32'sd10, 16'd3277, 0, 1);
    send_pos(32'sd412000, 32'sd401000, 32'sd0, 16'd3277, 0, 1);
    drain();

    // several gain settings, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 7; r++) begin
        logic [15:0] v;
        case (phase)
          0: v = 16'hffff;
          1: v = (r == 2 || r == 5) ? 16'd1 : 16'd0;
          2: v = 16'd1;
          default: v = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 1024));
        endcase
        if ((r == 2 || r == 5) && v == 0) v = 16'd1;
        if (r == RegBypass) v = phase == 1 ? 16'd0 : 16'($urandom_range(0, 3));
        write_reg(r[2:0], v);
      end
      if (phase == 3) write_reg(3'd7, 16'h1234);
      base_x = $signed($urandom_range(0, 200000)) - 100000;
      base_y = $signed($urandom_range(0, 200000)) - 100000;
      base_z = $signed($urandom_range(0, 20000)) - 10000;
      if (phase == 4) hold_off = 400;
      if (phase == 7) quiet_tail = 1;
      random_walk(102);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
sv/aps_pkg.sv
sv/aps_front.sv
sv/aps_queue.sv
sv/aps_div.sv
sv/aps_back.sv
sv/adaptive_position_smoother.sv
tb/adaptive_position_smoother_tb.sv
